// ===== hdl/humidity_sensor_readout_unit_defines.svh =====
// Assertion macros for the humidity sensor readout unit
`ifndef HUMIDITY_SENSOR_READOUT_UNIT_DEFINES_SVH
`define HUMIDITY_SENSOR_READOUT_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define HSR_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define HSR_ASSERT_NORST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HSR_ASSERT(lbl, clk, rstn, prop, msg)
`define HSR_ASSERT_NORST(lbl, clk, prop, msg)
`endif
`endif

// ===== hdl/hsr_pkg.sv =====
// Shared types and constants for the humidity sensor readout unit
package hsr_pkg;
  typedef enum logic [4:0] {
    PH_IDLE, PH_TS1, PH_TS2, PH_TS3, PH_TS4, PH_TS5, PH_TS6,
    PH_CMD_LOW, PH_CMD_HIGH, PH_ACK_HIGH, PH_ACK_LOW, PH_WAIT,
    PH_RD_HIGH, PH_RD_LOW, PH_MACK_SET, PH_MACK_HIGH, PH_MACK_LOW,
    PH_CRC_HIGH, PH_CRC_LOW, PH_CONV
  } phase_e;

  localparam logic [7:0] TEMP_COMMAND  = 8'd3;
  localparam logic [7:0] HUMID_COMMAND = 8'd5;

  localparam logic [2:0] REG_TEMP_OFFSET = 3'd0;
  localparam logic [2:0] REG_TEMP_GAIN   = 3'd1;
  localparam logic [2:0] REG_HUM_OFFSET  = 3'd2;
  localparam logic [2:0] REG_HUM_LINEAR  = 3'd3;
  localparam logic [2:0] REG_HUM_SQUARE  = 3'd4;
  localparam logic [2:0] REG_COMP_BASE   = 3'd5;
  localparam logic [2:0] REG_COMP_SLOPE  = 3'd6;
  localparam logic [2:0] REG_TIMEOUT     = 3'd7;

  typedef struct packed {
    logic [15:0] temp_offset;
    logic [15:0] temp_gain;
    logic [15:0] hum_offset;
    logic [23:0] hum_linear;
    logic [23:0] hum_square;
    logic [15:0] comp_base;
    logic [15:0] comp_slope;
    logic [7:0]  ready_timeout;
  } cfg_t;

  // controller -> datapath
  typedef struct packed {
    logic shift_in;     // shift data_in into word
    logic clr_word;
    logic store_raw;    // end of a read word
    logic hum_pass;
    logic conv_start;   // humidity conversion start
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic conv_done;
  } dp_sts_t;
endpackage

// ===== hdl/hsr_datapath.sv =====
// Shift register and sequential fixed-point conversion datapath
module hsr_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hsr_pkg::cfg_t       cfg_i,
  input  logic                din_i,
  input  hsr_pkg::dp_cmd_t    cmd_i,
  output hsr_pkg::dp_sts_t    sts_o,
  output logic signed [15:0]  temp_o,
  output logic signed [15:0]  hum_o
);
  import hsr_pkg::*;
  `include "humidity_sensor_readout_unit_defines.svh"

  logic [15:0] word_q, word_d;
  logic [15:0] raw_hum_q;
  logic signed [15:0] temp_q, hum_q;
  logic [3:0]  step_q;
  logic        busy_q;
  logic signed [63:0] acc_q;
  logic signed [49:0] prod_q;
  logic [32:0]  rsq_q;      // raw*raw
  logic signed [41:0] comp_q;

  // temperature: one 16x16 multiply, registered sum at word end
  logic [31:0] tprod;
  logic signed [33:0] tsum;
  assign tprod = word_d * cfg_i.temp_gain;
  assign tsum  = 34'(signed'(cfg_i.temp_offset))
               + 34'(signed'({2'b0, tprod} + 34'sd128) >>> 8);

  function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
    if (v > 64'sd32767) return 16'sh7fff;
    if (v < -64'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  always_comb begin
    word_d = word_q;
    if (cmd_i.clr_word) word_d = '0;
    else if (cmd_i.shift_in) word_d = {word_q[14:0], din_i};
  end

  logic signed [63:0] hfinal;
  assign hfinal = (acc_q + (64'sd1 <<< 31)) >>> 32;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q <= '0; raw_hum_q <= '0; temp_q <= '0; hum_q <= '0;
      step_q <= '0; busy_q <= 1'b0;
    end else begin
      word_q <= word_d;
      if (cmd_i.store_raw) begin
        if (cmd_i.hum_pass) raw_hum_q <= word_q;
        else temp_q <= sat16(64'(tsum));
      end
      if (cmd_i.conv_start) begin
        busy_q <= 1'b1; step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 4'd1;
        if (step_q == 4'd8) begin
          busy_q <= 1'b0;
          hum_q  <= sat16(hfinal);
        end
      end
    end
  end

  // at most one multiply per step, accumulated
  always_ff @(posedge clk_i) begin
    if (cmd_i.conv_start) begin
      acc_q <= 64'(signed'(cfg_i.hum_offset)) <<< 32;
    end else if (busy_q) begin
      unique case (step_q)
        4'd0: prod_q <= 50'(signed'({1'b0, cfg_i.hum_linear}))
                      * 50'(signed'({1'b0, raw_hum_q}));
        4'd1: begin
          acc_q <= acc_q + (64'(prod_q) <<< 16);
          rsq_q <= 33'(raw_hum_q * raw_hum_q);
        end
        4'd2: prod_q <= 50'(signed'(cfg_i.hum_square)) * 50'(signed'(rsq_q[31:0] >> 16));
        4'd3: begin
          acc_q <= acc_q + (64'(prod_q) <<< 16);
          prod_q <= 50'(signed'(cfg_i.hum_square)) * 50'(signed'({1'b0, rsq_q[15:0]}));
        end
        4'd4: begin
          acc_q <= acc_q + 64'(prod_q);
          prod_q <= 50'(signed'({1'b0, cfg_i.comp_slope}))
                  * 50'(signed'({1'b0, raw_hum_q}));
        end
        4'd5: comp_q <= 42'(prod_q) + 42'({cfg_i.comp_base, 8'd0});
        // temperature term can exceed 2^47 at full scale
        4'd6: prod_q <= 50'(64'(temp_q) - 64'sd2500) * signed'(50'(comp_q[33:0]));
        4'd7: acc_q <= acc_q + (64'(prod_q) <<< 8);
        default: ;
      endcase
    end
  end

  assign sts_o.conv_done = busy_q && (step_q == 4'd8);
  assign temp_o = temp_q;
  assign hum_o  = hum_q;

  `HSR_ASSERT(a_no_restart, clk_i, rst_ni, busy_q |-> !cmd_i.conv_start, "conv restart")
  `HSR_ASSERT(a_step_rng, clk_i, rst_ni, busy_q |-> step_q <= 4'd8, "step range")
  `HSR_ASSERT(a_done_end, clk_i, rst_ni, sts_o.conv_done |=> !busy_q, "busy after done")
endmodule

// ===== hdl/hsr_controller.sv =====
// Pin sequencing state machine for the sensor transfer cycle
module hsr_controller (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hsr_pkg::cfg_t     cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              start_req_i,
  input  logic              data_in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              clock_out_o,
  output logic              data_out_o,
  output logic              data_enable_o,
  output logic              done_res_o,
  output logic              report_o,
  output logic              timed_out_o,
  output logic [7:0]        error_count_o,
  output hsr_pkg::dp_cmd_t  cmd_o,
  input  hsr_pkg::dp_sts_t  sts_i
);
  import hsr_pkg::*;
  `include "humidity_sensor_readout_unit_defines.svh"

  phase_e      ph_q, ph_d;
  logic [4:0]  bit_q, bit_d;
  logic [7:0]  wait_q, wait_d;
  logic [7:0]  tot_q, tot_d;
  logic        hum_q, hum_d;
  logic        ov_q, ov_d;
  logic        clk_q, clk_d, do_q, do_d, den_q, den_d, done_q, done_d;
  logic        rep_q, rep_d, tmo_q, tmo_d;
  logic        acc;
  logic [7:0]  cmd, limit, wnext;

  assign in_ready_o = (ph_q != PH_CONV) && (!ov_q || out_ready_i);
  assign acc   = in_valid_i && in_ready_o;
  assign cmd   = hum_q ? HUMID_COMMAND : TEMP_COMMAND;
  assign limit = (cfg_i.ready_timeout == 8'd0) ? 8'd1 : cfg_i.ready_timeout;
  assign wnext = wait_q + 8'd1;

  // next state
  always_comb begin
    ph_d = ph_q; bit_d = bit_q; wait_d = wait_q; tot_d = tot_q; hum_d = hum_q;
    if (ph_q == PH_CONV) begin
      if (sts_i.conv_done) begin ph_d = PH_IDLE; hum_d = 1'b0; end
    end else if (acc) begin
      unique case (ph_q)
        PH_IDLE: if (start_req_i) begin ph_d = PH_TS1; hum_d = 1'b0; end
        PH_TS1: ph_d = PH_TS2;
        PH_TS2: ph_d = PH_TS3;
        PH_TS3: ph_d = PH_TS4;
        PH_TS4: ph_d = PH_TS5;
        PH_TS5: ph_d = PH_TS6;
        PH_TS6: begin ph_d = PH_CMD_LOW; bit_d = '0; end
        PH_CMD_LOW: ph_d = PH_CMD_HIGH;
        PH_CMD_HIGH: begin
          bit_d = bit_q + 5'd1;
          ph_d = (bit_d >= 5'd8) ? PH_ACK_HIGH : PH_CMD_LOW;
        end
        PH_ACK_HIGH: ph_d = PH_ACK_LOW;
        PH_ACK_LOW: begin wait_d = '0; ph_d = PH_WAIT; end
        PH_WAIT: begin
          if (!data_in_i) begin
            bit_d = '0; ph_d = PH_RD_HIGH;
          end else begin
            wait_d = wnext;
            if (wnext >= limit) begin
              if (tot_q != 8'hff) tot_d = tot_q + 8'd1;
              ph_d = PH_IDLE; hum_d = 1'b0;
            end
          end
        end
        PH_RD_HIGH: begin bit_d = bit_q + 5'd1; ph_d = PH_RD_LOW; end
        PH_RD_LOW: begin
          if (bit_q == 5'd8) ph_d = PH_MACK_SET;
          else if (bit_q >= 5'd16) ph_d = PH_CRC_HIGH;
          else ph_d = PH_RD_HIGH;
        end
        PH_MACK_SET: ph_d = PH_MACK_HIGH;
        PH_MACK_HIGH: ph_d = PH_MACK_LOW;
        PH_MACK_LOW: ph_d = PH_RD_HIGH;
        PH_CRC_HIGH: ph_d = PH_CRC_LOW;
        PH_CRC_LOW: begin
          if (hum_q) ph_d = PH_CONV;
          else begin hum_d = 1'b1; ph_d = PH_TS1; end
        end
        default: begin ph_d = PH_IDLE; hum_d = 1'b0; end
      endcase
    end
  end

  // outputs
  always_comb begin
    clk_d = clk_q; do_d = do_q; den_d = den_q; done_d = done_q;
    rep_d = rep_q; tmo_d = tmo_q;
    ov_d = ov_q && !out_ready_i;
    cmd_o = '0;
    cmd_o.hum_pass = hum_q;
    if (ph_q == PH_CONV) begin
      if (sts_i.conv_done) begin
        ov_d = 1'b1; clk_d = 1'b0; do_d = 1'b1; den_d = 1'b1;
        done_d = 1'b1; rep_d = 1'b1; tmo_d = 1'b0;
      end
    end else if (acc) begin
      ov_d = 1'b1;
      clk_d = 1'b0; do_d = 1'b0; den_d = 1'b0; done_d = 1'b0;
      rep_d = 1'b0; tmo_d = 1'b0;
      unique case (ph_q)
        PH_TS1, PH_TS5: begin clk_d = 1'b1; do_d = 1'b1; den_d = 1'b1; end
        PH_TS2, PH_TS4: begin clk_d = 1'b1; den_d = 1'b1; end
        PH_TS3: den_d = 1'b1;
        PH_TS6: begin do_d = 1'b1; den_d = 1'b1; end
        PH_CMD_LOW, PH_CMD_HIGH: begin
          den_d = 1'b1;
          do_d  = cmd[3'd7 - bit_q[2:0]];
          clk_d = (ph_q == PH_CMD_HIGH);
        end
        PH_ACK_HIGH: clk_d = 1'b1;
        PH_WAIT: begin
          if (!data_in_i) cmd_o.clr_word = 1'b1;
          else if (wnext >= limit) begin done_d = 1'b1; tmo_d = 1'b1; end
        end
        PH_RD_HIGH: begin clk_d = 1'b1; cmd_o.shift_in = 1'b1; end
        PH_RD_LOW: if (bit_q != 5'd8 && bit_q >= 5'd16) cmd_o.store_raw = 1'b1;
        PH_MACK_SET, PH_MACK_LOW: den_d = 1'b1;
        PH_MACK_HIGH: begin den_d = 1'b1; clk_d = 1'b1; end
        PH_CRC_HIGH: begin den_d = 1'b1; do_d = 1'b1; clk_d = 1'b1; end
        PH_CRC_LOW: begin
          den_d = 1'b1; do_d = 1'b1;
          if (hum_q) begin ov_d = 1'b0; cmd_o.conv_start = 1'b1; end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PH_IDLE; bit_q <= '0; wait_q <= '0; tot_q <= '0; hum_q <= 1'b0;
      ov_q <= 1'b0; clk_q <= 1'b0; do_q <= 1'b0; den_q <= 1'b0;
      done_q <= 1'b0; rep_q <= 1'b0; tmo_q <= 1'b0;
    end else begin
      ph_q <= ph_d; bit_q <= bit_d; wait_q <= wait_d; tot_q <= tot_d;
      hum_q <= hum_d; ov_q <= ov_d; clk_q <= clk_d; do_q <= do_d;
      den_q <= den_d; done_q <= done_d; rep_q <= rep_d; tmo_q <= tmo_d;
    end
  end

  assign out_valid_o   = ov_q;
  assign clock_out_o   = clk_q;
  assign data_out_o    = do_q;
  assign data_enable_o = den_q;
  assign done_res_o    = done_q;
  assign report_o      = rep_q;
  assign timed_out_o   = tmo_q;
  assign error_count_o = tot_q;

  `HSR_ASSERT(a_conv_noin, clk_i, rst_ni, (ph_q == PH_CONV) |-> !in_ready_o, "input during conv")
  `HSR_ASSERT(a_rep_done, clk_i, rst_ni, (rep_q || tmo_q) |-> done_q, "report without done")
  `HSR_ASSERT(a_tot_mono, clk_i, rst_ni, tot_q >= $past(tot_q), "error count fell")
endmodule

// ===== hdl/humidity_sensor_readout_unit.sv =====
// Top level of the humidity sensor readout unit
// Channel  | Signals                                   | Direction
// in       | in_valid_i/in_ready_o, start_req_i, data_in_i | input, one pin tick each
// out      | out_valid_o/out_ready_i, result fields    | output, one result per tick
// cfg      | cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i | register write
// One tick per cycle while the output drains and no conversion runs; the final
// humidity tick starts the sequential conversion (eight datapath steps).
// Reset loads register defaults and returns the sequencer to idle.
// An output register holds each result; a new tick is taken when it drains.
module humidity_sensor_readout_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               start_req_i,
  input  logic               data_in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               clock_out_o,
  output logic               data_out_o,
  output logic               data_enable_o,
  output logic               done_res_o,
  output logic signed [15:0] temperature_o,
  output logic signed [15:0] humidity_o,
  output logic               temp_range_error_o,
  output logic               hum_range_error_o,
  output logic               timed_out_o,
  output logic [7:0]         error_count_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [23:0]        cfg_data_i
);
  import hsr_pkg::*;

  cfg_t     cfg_q;
  dp_cmd_t  cmd;
  dp_sts_t  sts;
  logic     report;
  logic signed [15:0] t_val, h_val;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.temp_offset   <= 16'hf060;
      cfg_q.temp_gain     <= 16'd256;
      cfg_q.hum_offset    <= 16'hfe70;
      cfg_q.hum_linear    <= 24'd265421;
      cfg_q.hum_square    <= 24'hEDA661;
      cfg_q.comp_base     <= 16'd655;
      cfg_q.comp_slope    <= 16'd1342;
      cfg_q.ready_timeout <= 8'd11;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_TEMP_OFFSET: cfg_q.temp_offset   <= cfg_data_i[15:0];
        REG_TEMP_GAIN:   cfg_q.temp_gain     <= cfg_data_i[15:0];
        REG_HUM_OFFSET:  cfg_q.hum_offset    <= cfg_data_i[15:0];
        REG_HUM_LINEAR:  cfg_q.hum_linear    <= cfg_data_i;
        REG_HUM_SQUARE:  cfg_q.hum_square    <= cfg_data_i;
        REG_COMP_BASE:   cfg_q.comp_base     <= cfg_data_i[15:0];
        REG_COMP_SLOPE:  cfg_q.comp_slope    <= cfg_data_i[15:0];
        REG_TIMEOUT:     cfg_q.ready_timeout <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  hsr_controller u_ctrl (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .in_valid_i, .in_ready_o, .start_req_i,
    .data_in_i, .out_valid_o, .out_ready_i, .clock_out_o, .data_out_o,
    .data_enable_o, .done_res_o, .report_o(report), .timed_out_o,
    .error_count_o, .cmd_o(cmd), .sts_i(sts)
  );

  hsr_datapath u_dp (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .din_i(data_in_i), .cmd_i(cmd),
    .sts_o(sts), .temp_o(t_val), .hum_o(h_val)
  );

  assign temperature_o      = report ? t_val : 16'sd0;
  assign humidity_o         = report ? h_val : 16'sd0;
  assign temp_range_error_o = report && (t_val <= -16'sd6000 || t_val >= 16'sd15000);
  assign hum_range_error_o  = report && (h_val <= 16'sd100 || h_val >= 16'sd9990);
endmodule

// ===== test/tb_humidity_sensor_readout_unit.sv =====
// Testbench for the humidity sensor readout unit: predicts every pin tick and checks results
module tb_humidity_sensor_readout_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import hsr_pkg::*;

  typedef struct {
    logic        clk_lvl;
    logic        dout;
    logic        den;
    logic        done;
    logic [15:0] temp;
    logic [15:0] hum;
    logic        terr;
    logic        herr;
    logic        tmo;
    logic [7:0]  errs;
  } tick_res_t;

  // Sequencer predictor plus the queue of expected ticks
  class readout_scoreboard;
    logic [15:0] t_off, t_gain, h_off, c_base, c_slope;
    logic [23:0] h_lin, h_sq;
    logic [7:0]  rdy_tmo;
    phase_e      ph;
    int unsigned bit_cnt, wait_cnt, raw_hum, tmo_total;
    int unsigned shift_acc;
    int          temp_val;
    bit          hum_pass;
    tick_res_t   pending[$];
    int          n_fail;

    function void reset_state();
      t_off = 16'hF060; t_gain = 256; h_off = 16'hFE70; h_lin = 265421;
      h_sq = 24'hEDA661; c_base = 655; c_slope = 1342; rdy_tmo = 11;
      ph = PH_IDLE; bit_cnt = 0; wait_cnt = 0; raw_hum = 0; temp_val = 0;
      tmo_total = 0; hum_pass = 0; n_fail = 0; shift_acc = 0;
      pending.delete();
    endfunction

    function void write_reg(logic [2:0] idx, logic [23:0] d);
      case (idx)
        REG_TEMP_OFFSET: t_off = d[15:0];
        REG_TEMP_GAIN:   t_gain = d[15:0];
        REG_HUM_OFFSET:  h_off = d[15:0];
        REG_HUM_LINEAR:  h_lin = d;
        REG_HUM_SQUARE:  h_sq = d;
        REG_COMP_BASE:   c_base = d[15:0];
        REG_COMP_SLOPE:  c_slope = d[15:0];
        REG_TIMEOUT:     rdy_tmo = d[7:0];
        default: ;
      endcase
    endfunction

    function longint floor_shr(longint v, int s);
      return v >>> s;
    endfunction

    function int clamp16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return int'(v);
    endfunction

    function int temp_of(int unsigned raw);
      longint p;
      p = longint'(raw) * longint'(t_gain);
      return clamp16(longint'($signed(t_off)) + floor_shr(p + 128, 8));
    endfunction

    function int hum_of(int unsigned raw, int t);
      longint r, comp, acc;
      r = raw;
      comp = longint'(c_base) * 256 + longint'(c_slope) * r;
      acc = longint'($signed(h_off)) <<< 32;
      acc += longint'(h_lin) * r * 65536;
      acc += longint'($signed(h_sq)) * (r * r);
      acc += (longint'(t) - 2500) * comp * 256;
      return clamp16(floor_shr(acc + (longint'(1) <<< 31), 32));
    endfunction

    function void note_tick(bit start, bit din);
      tick_res_t e;
      logic [7:0] cmd;
      int unsigned lim;
      int hv;
      e = '{default: 0};
      cmd = hum_pass ? HUMID_COMMAND : TEMP_COMMAND;
      case (ph)
        PH_IDLE: if (start) begin ph = PH_TS1; hum_pass = 0; end
        PH_TS1: begin e.clk_lvl = 1; e.dout = 1; e.den = 1; ph = PH_TS2; end
        PH_TS2: begin e.clk_lvl = 1; e.den = 1; ph = PH_TS3; end
        PH_TS3: begin e.den = 1; ph = PH_TS4; end
        PH_TS4: begin e.clk_lvl = 1; e.den = 1; ph = PH_TS5; end
        PH_TS5: begin e.clk_lvl = 1; e.dout = 1; e.den = 1; ph = PH_TS6; end
        PH_TS6: begin e.dout = 1; e.den = 1; bit_cnt = 0; ph = PH_CMD_LOW; end
        PH_CMD_LOW, PH_CMD_HIGH: begin
          e.den = 1;
          e.dout = cmd[7 - (bit_cnt & 7)];
          if (ph == PH_CMD_LOW) ph = PH_CMD_HIGH;
          else begin
            e.clk_lvl = 1;
            bit_cnt = (bit_cnt + 1) & 31;
            ph = (bit_cnt >= 8) ? PH_ACK_HIGH : PH_CMD_LOW;
          end
        end
        PH_ACK_HIGH: begin e.clk_lvl = 1; ph = PH_ACK_LOW; end
        PH_ACK_LOW: begin wait_cnt = 0; ph = PH_WAIT; end
        PH_WAIT: begin
          if (!din) begin
            bit_cnt = 0; raw_hum = raw_hum; ph = PH_RD_HIGH;
            shift_acc = 0;
          end else begin
            lim = (rdy_tmo == 0) ? 1 : rdy_tmo;
            wait_cnt = (wait_cnt + 1) & 8'hFF;
            if (wait_cnt >= lim) begin
              e.done = 1; e.tmo = 1;
              if (tmo_total < 255) tmo_total++;
              ph = PH_IDLE; hum_pass = 0;
            end
          end
        end
        PH_RD_HIGH: begin
          e.clk_lvl = 1;
          shift_acc = ((shift_acc << 1) | din) & 16'hFFFF;
          bit_cnt = (bit_cnt + 1) & 31;
          ph = PH_RD_LOW;
        end
        PH_RD_LOW: begin
          if (bit_cnt == 8) ph = PH_MACK_SET;
          else if (bit_cnt >= 16) begin
            if (hum_pass) raw_hum = shift_acc;
            else temp_val = temp_of(shift_acc);
            ph = PH_CRC_HIGH;
          end else ph = PH_RD_HIGH;
        end
        PH_MACK_SET: begin e.den = 1; ph = PH_MACK_HIGH; end
        PH_MACK_HIGH: begin e.den = 1; e.clk_lvl = 1; ph = PH_MACK_LOW; end
        PH_MACK_LOW: begin e.den = 1; ph = PH_RD_HIGH; end
        PH_CRC_HIGH: begin e.den = 1; e.dout = 1; e.clk_lvl = 1; ph = PH_CRC_LOW; end
        PH_CRC_LOW: begin
          e.den = 1; e.dout = 1;
          if (hum_pass) begin
            hv = hum_of(raw_hum, temp_val);
            e.temp = temp_val[15:0];
            e.hum = hv[15:0];
            e.terr = (temp_val <= -6000 || temp_val >= 15000);
            e.herr = (hv <= 100 || hv >= 9990);
            e.done = 1; hum_pass = 0; ph = PH_IDLE;
          end else begin
            hum_pass = 1; ph = PH_TS1;
          end
        end
        default: begin ph = PH_IDLE; hum_pass = 0; end
      endcase
      e.errs = tmo_total[7:0];
      pending.push_back(e);
    endfunction

    function void check_tick(tick_res_t a);
      tick_res_t e;
      if (pending.size() == 0) begin
        $error("result transfer with nothing expected");
        n_fail++;
        return;
      end
      e = pending.pop_front();
      if (a.clk_lvl !== e.clk_lvl) fail_field("clock_out", e.clk_lvl, a.clk_lvl);
      if (a.dout !== e.dout) fail_field("data_out", e.dout, a.dout);
      if (a.den !== e.den) fail_field("data_enable", e.den, a.den);
      if (a.done !== e.done) fail_field("done_res", e.done, a.done);
      if (a.temp !== e.temp) fail_field("temperature", e.temp, a.temp);
      if (a.hum !== e.hum) fail_field("humidity", e.hum, a.hum);
      if (a.terr !== e.terr) fail_field("temp_range_error", e.terr, a.terr);
      if (a.herr !== e.herr) fail_field("hum_range_error", e.herr, a.herr);
      if (a.tmo !== e.tmo) fail_field("timed_out", e.tmo, a.tmo);
      if (a.errs !== e.errs) fail_field("error_count", e.errs, a.errs);
    endfunction

    function void fail_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      n_fail++;
    endfunction
  endclass

  logic               clk_i = 0;
  logic               rst_ni = 0;
  logic               in_valid_i = 0;
  logic               in_ready_o;
  logic               start_req_i = 0;
  logic               data_in_i = 0;
  logic               out_valid_o;
  logic               out_ready_i = 0;
  logic               clock_out_o, data_out_o, data_enable_o, done_res_o;
  logic signed [15:0] temperature_o, humidity_o;
  logic               temp_range_error_o, hum_range_error_o, timed_out_o;
  logic [7:0]         error_count_o;
  logic               cfg_valid_i = 0;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i = '0;
  logic [23:0]        cfg_data_i = '0;

  readout_scoreboard sb;
  bit quiet_tail;
  int hold_off;   // long receiver stall, cycles
  int n_sent;     // input transfers so far

  humidity_sensor_readout_unit i_dut (.*);

  always begin
    #1 clk_i = 1;
    #1 clk_i = 0;
  end

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

  // Receiver: random stalls, plus long hold-offs on request
  initial begin
    int gap;
    forever begin
      @(posedge clk_i);
      if (hold_off > 0) begin
        out_ready_i <= 0;
        hold_off--;
      end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
        out_ready_i <= 0;
        gap = $urandom_range(1, 8);
        repeat (gap - 1) @(posedge clk_i);
        out_ready_i <= 1;
      end else out_ready_i <= 1;
    end
  end

  always @(posedge clk_i) begin
    tick_res_t a;
    if (rst_ni && out_valid_o && out_ready_i) begin
      a.clk_lvl = clock_out_o; a.dout = data_out_o; a.den = data_enable_o;
      a.done = done_res_o; a.temp = temperature_o; a.hum = humidity_o;
      a.terr = temp_range_error_o; a.herr = hum_range_error_o;
      a.tmo = timed_out_o; a.errs = error_count_o;
      sb.check_tick(a);
    end
  end

  task automatic send_tick(bit start, bit din);
    int gap;
    if (!quiet_tail && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1;
    start_req_i <= start;
    data_in_i <= din;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_tick(start, din);
    n_sent++;
  endtask

  task automatic set_reg(logic [2:0] idx, logic [23:0] d);
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 0;
    sb.write_reg(idx, d);
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // One full measurement: the sensor answers after `delay` polls with two words
  task automatic measure(int delay, logic [15:0] t_raw, logic [15:0] h_raw, bit noisy);
    int n;
    logic [15:0] w;
    send_tick(1, 1'($urandom_range(0, 1)));
    for (int pass = 0; pass < 2; pass++) begin
      w = pass ? h_raw : t_raw;
      for (n = 0; n < 24; n++)
        send_tick(noisy & 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      for (n = 0; n < delay; n++) begin
        send_tick(0, 1);
        if (sb.ph == PH_IDLE) return;
      end
      send_tick(0, 0);
      for (n = 0; n < 16; n++) begin
        send_tick(0, w[15 - n]);
        send_tick(0, 1'($urandom_range(0, 1)));
        if (n == 7) repeat (3) send_tick(0, 1'($urandom_range(0, 1)));
      end
      send_tick(0, 1'($urandom_range(0, 1)));
      send_tick(0, 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic random_cfg(bit extreme);
    set_reg(REG_TEMP_OFFSET, extreme ? 24'h008000 : 24'($urandom));
    set_reg(REG_TEMP_GAIN, extreme ? 24'hFFFF : 24'($urandom_range(0, 600)));
    set_reg(REG_HUM_OFFSET, extreme ? 24'h7FFF : 24'($urandom));
    set_reg(REG_HUM_LINEAR, extreme ? 24'hFFFFFF : 24'($urandom));
    set_reg(REG_HUM_SQUARE, extreme ? 24'h800000 : 24'($urandom));
    set_reg(REG_COMP_BASE, extreme ? 24'hFFFF : 24'($urandom));
    set_reg(REG_COMP_SLOPE, extreme ? 24'hFFFF : 24'($urandom));
    set_reg(REG_TIMEOUT, extreme ? 24'hFF : 24'($urandom_range(1, 20)));
  endtask

  initial begin
    int cnt;
    sb = new();
    sb.reset_state();
    hold_off = 0;
    quiet_tail = 0;
    n_sent = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: extreme raw words, a timeout, start while busy
    measure(0, 16'h0000, 16'hFFFF, 1);
    measure(3, 16'hFFFF, 16'h0000, 0);
    measure(20, 16'h1234, 16'h0800, 0);
    drain();
    random_cfg(1);
    measure(2, 16'hFFFF, 16'hFFFF, 1);
    measure(300, 16'h0, 16'h0, 0);
    drain();
    set_reg(REG_TIMEOUT, 24'h1);
    set_reg(REG_TEMP_OFFSET, 24'h7FFF);
    measure(1, 16'h8000, 16'h7FFF, 0);
    drain();
    set_reg(REG_TIMEOUT, 24'h0);
    measure(1, 16'h0, 16'h0, 0);
    drain();

    cnt = 0;
    while (n_sent < 1850) begin
      cnt = sb.pending.size();
      if (cnt == 0 && $urandom_range(0, 7) == 0) begin
        drain();
        random_cfg($urandom_range(0, 3) == 0);
      end
      if (n_sent > 1000 && n_sent < 1400 && hold_off == 0 && cnt < 3) hold_off = 300;
      if (n_sent > 1700) quiet_tail = 1;
      if ($urandom_range(0, 9) == 0) begin
        repeat (8) send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else begin
        measure($urandom_range(0, 1) ? $urandom_range(0, 4) : $urandom_range(0, 30),
                16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)));
      end
    end
    in_valid_i <= 0;
    hold_off = 0;
    cnt = 0;
    while (sb.pending.size() != 0 && cnt < 100000) begin
      @(posedge clk_i);
      cnt++;
    end
    repeat (30) @(posedge clk_i);
    if (sb.n_fail == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+hdl
hdl/hsr_pkg.sv
hdl/hsr_datapath.sv
hdl/hsr_controller.sv
hdl/humidity_sensor_readout_unit.sv
test/tb_humidity_sensor_readout_unit.sv
